// ===== rtl/jc_pkg.sv =====
// Shared types, constants and a helper function for the joystick conditioner.
// No dependencies; used by every module of the block.
package jc_pkg;

    localparam int unsigned DEAD_ZONE_DEF     = 200;
    localparam int unsigned Y_OFFSET_DEF      = 52;
    localparam int unsigned SCREEN_WIDTH_DEF  = 128;
    localparam int unsigned SCREEN_HEIGHT_DEF = 64;

    localparam int unsigned CENTRE = 2048;
    localparam int unsigned FULL   = 4095;

    localparam logic [23:0] DEBOUNCE_RST = 24'd200000;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_STICK  = 2'd1;
    localparam logic [1:0] KIND_BTN_A  = 2'd2;

    // Reciprocal multiply widths and shifts for the constant divisions.
    localparam int unsigned CAL_N_BITS  = 24;
    localparam int unsigned CAL_M_W     = 25;
    localparam int unsigned LEVEL_SHIFT = 30;
    localparam int unsigned LEVEL_M_W   = 21;
    localparam int unsigned POS_SHIFT   = 32;
    localparam int unsigned POS_M_W     = 21;
    localparam logic [POS_M_W-1:0] POS_RECIP = 21'd1048833;

    typedef struct packed {
        logic       sample;
        logic       clr;
        logic       pwm;
        logic [1:0] style;
    } t_ctl;

    typedef struct packed {
        logic b;
        logic c;
    } t_adv;

    function automatic logic [11:0] snap(input logic [11:0] v, input logic [11:0] lo,
                                         input logic [11:0] hi);
        snap = (v > lo && v < hi) ? 12'(CENTRE) : v;
    endfunction

endpackage

// ===== rtl/jc_state.sv =====
// Front stage: configuration register, axis filters, debounce and mode state.
// Depends on jc_pkg.
module jc_state #(
    parameter int unsigned DEAD_ZONE = jc_pkg::DEAD_ZONE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [23:0]       i_cfg_wr_data,
    input  logic              i_accept,
    input  logic [1:0]        i_kind,
    input  logic [11:0]       i_sample_x,
    input  logic [11:0]       i_sample_y,
    input  logic [47:0]       i_time_us,
    output jc_pkg::t_ctl      o_ctl,
    output logic [11:0]       o_fx,
    output logic [11:0]       o_fy
);

    localparam logic [11:0] SNAP_LO = 12'(jc_pkg::CENTRE - DEAD_ZONE);
    localparam logic [11:0] SNAP_HI = 12'(jc_pkg::CENTRE + DEAD_ZONE);

    logic [23:0]  r_debounce;
    logic [11:0]  r_fx, r_fy;
    logic         r_pwm;
    logic [1:0]   r_style;
    logic [47:0]  r_last_stick, r_last_a;
    jc_pkg::t_ctl r_ctl;

    logic [12:0]  sum_x, sum_y;
    logic [11:0]  n_fx, n_fy;
    logic         stick_ok, a_ok;
    logic [1:0]   n_style;
    logic         n_pwm;

    always_comb begin
        sum_x    = {1'b0, i_sample_x} + {1'b0, r_fx};
        sum_y    = {1'b0, i_sample_y} + {1'b0, r_fy};
        n_fx     = jc_pkg::snap(sum_x[12:1], SNAP_LO, SNAP_HI);
        n_fy     = sum_y[12:1];
        stick_ok = (i_time_us >= r_last_stick) &&
                   ((i_time_us - r_last_stick) >= {24'b0, r_debounce});
        a_ok     = (i_time_us >= r_last_a) &&
                   ((i_time_us - r_last_a) >= {24'b0, r_debounce});
        n_style  = r_style;
        n_pwm    = r_pwm;
        case (i_kind)
            jc_pkg::KIND_STICK: begin
                if (stick_ok) begin
                    n_style = r_style + 2'd1;
                end
            end
            jc_pkg::KIND_BTN_A: begin
                if (a_ok) begin
                    n_pwm = ~r_pwm;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= jc_pkg::DEBOUNCE_RST;
            r_fx         <= 12'(jc_pkg::CENTRE);
            r_fy         <= 12'(jc_pkg::CENTRE);
            r_pwm        <= 1'b1;
            r_style      <= 2'd0;
            r_last_stick <= '0;
            r_last_a     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_debounce <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_style <= n_style;
                r_pwm   <= n_pwm;
                case (i_kind)
                    jc_pkg::KIND_SAMPLE: begin
                        r_fx <= n_fx;
                        r_fy <= n_fy;
                    end
                    jc_pkg::KIND_STICK: begin
                        if (stick_ok) begin
                            r_last_stick <= i_time_us;
                        end
                    end
                    jc_pkg::KIND_BTN_A: begin
                        if (a_ok) begin
                            r_last_a <= i_time_us;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_ctl.sample <= (i_kind == jc_pkg::KIND_SAMPLE);
            r_ctl.clr    <= (i_kind == jc_pkg::KIND_BTN_A) && a_ok && r_pwm;
            r_ctl.pwm    <= n_pwm;
            r_ctl.style  <= n_style;
        end
    end

    // Filter state only moves when a new item is accepted into this stage, so it is the item's value.
    assign o_ctl = r_ctl;
    assign o_fx  = r_fx;
    assign o_fy  = r_fy;

endmodule

// ===== rtl/jc_map.sv =====
// Two mapping stages: Y calibration, dead zone, PWM levels and square position.
// Depends on jc_pkg; constant divisions use reciprocal multiplies.
module jc_map #(
    parameter int unsigned DEAD_ZONE     = jc_pkg::DEAD_ZONE_DEF,
    parameter int unsigned Y_OFFSET      = jc_pkg::Y_OFFSET_DEF,
    parameter int unsigned SCREEN_WIDTH  = jc_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = jc_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic              i_clk,
    input  jc_pkg::t_adv      i_adv,
    input  jc_pkg::t_ctl      i_ctl,
    input  logic [11:0]       i_fx,
    input  logic [11:0]       i_fy,
    output jc_pkg::t_ctl      o_ctl,
    output logic [7:0]        o_red,
    output logic [7:0]        o_blue,
    output logic [6:0]        o_pos_x,
    output logic [5:0]        o_pos_y
);

    localparam int unsigned LO    = jc_pkg::CENTRE - DEAD_ZONE;
    localparam int unsigned HI    = jc_pkg::CENTRE + DEAD_ZONE;
    localparam int unsigned TOP   = jc_pkg::FULL - HI;
    localparam int unsigned SPAN  = jc_pkg::FULL - Y_OFFSET;
    localparam int unsigned S_CAL = jc_pkg::CAL_N_BITS + $clog2(SPAN);

    localparam longint unsigned M_CAL_L = (64'd1 << S_CAL) / SPAN + 1;
    localparam longint unsigned M_LO_L  = (64'd1 << jc_pkg::LEVEL_SHIFT) / LO + 1;
    localparam longint unsigned M_HI_L  = (64'd1 << jc_pkg::LEVEL_SHIFT) / TOP + 1;

    localparam logic [jc_pkg::CAL_M_W-1:0]   M_CAL = jc_pkg::CAL_M_W'(M_CAL_L);
    localparam logic [jc_pkg::LEVEL_M_W-1:0] M_LO  = jc_pkg::LEVEL_M_W'(M_LO_L);
    localparam logic [jc_pkg::LEVEL_M_W-1:0] M_HI  = jc_pkg::LEVEL_M_W'(M_HI_L);

    localparam logic [11:0] LO12   = 12'(LO);
    localparam logic [11:0] HI12   = 12'(HI);
    localparam logic [11:0] YOFF12 = 12'(Y_OFFSET);
    localparam logic [11:0] SPAN12 = 12'(SPAN);
    localparam logic [11:0] FULL12 = 12'(jc_pkg::FULL);
    localparam logic [19:0] W_M8   = 20'(SCREEN_WIDTH - 8);
    localparam logic [19:0] H_M8   = 20'(SCREEN_HEIGHT - 8);

    function automatic logic [7:0] level_of(input logic [11:0] v);
        logic        lo_side;
        logic        hi_side;
        logic [11:0] d;
        logic [19:0] n;
        logic [jc_pkg::LEVEL_M_W-1:0] m;
        logic [40:0] p;
        lo_side  = v < LO12;
        hi_side  = v > HI12;
        d        = lo_side ? LO12 - v : (hi_side ? v - HI12 : 12'd0);
        n        = {d, 8'b0} - {8'b0, d};
        m        = lo_side ? M_LO : M_HI;
        p        = 41'(n) * 41'(m);
        level_of = p[jc_pkg::LEVEL_SHIFT +: 8];
    endfunction

    jc_pkg::t_ctl r_b_ctl, r_c_ctl;
    logic [11:0]  r_b_cy;
    logic [7:0]   r_b_red, r_c_red, r_c_blue;
    logic [19:0]  r_b_xprod, r_c_yprod;
    logic [6:0]   r_c_pos_x;

    logic [11:0]  c_raw, c_clamp, cy_snap;
    logic [23:0]  n_cal;
    logic [48:0]  cal_p;
    logic [40:0]  xpos_p, ypos_p;

    always_comb begin
        c_raw   = (i_fy >= YOFF12) ? i_fy - YOFF12 : 12'd0;
        c_clamp = (c_raw > SPAN12) ? SPAN12 : c_raw;
        n_cal   = {c_clamp, 12'b0} - {12'b0, c_clamp};
        cal_p   = 49'(n_cal) * 49'(M_CAL);
        cy_snap = jc_pkg::snap(r_b_cy, LO12, HI12);
        xpos_p  = 41'(r_b_xprod) * 41'(jc_pkg::POS_RECIP);
        ypos_p  = 41'(r_c_yprod) * 41'(jc_pkg::POS_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.b) begin
            r_b_ctl   <= i_ctl;
            r_b_cy    <= cal_p[S_CAL +: 12];
            r_b_red   <= level_of(i_fx);
            r_b_xprod <= 20'(i_fx) * W_M8;
        end
        if (i_adv.c) begin
            r_c_ctl   <= r_b_ctl;
            r_c_red   <= r_b_red;
            r_c_blue  <= level_of(cy_snap);
            r_c_pos_x <= xpos_p[jc_pkg::POS_SHIFT +: 7];
            r_c_yprod <= 20'(FULL12 - cy_snap) * H_M8;
        end
    end

    assign o_ctl   = r_c_ctl;
    assign o_red   = r_c_red;
    assign o_blue  = r_c_blue;
    assign o_pos_x = r_c_pos_x;
    assign o_pos_y = ypos_p[jc_pkg::POS_SHIFT +: 6];

endmodule

// ===== rtl/joystick_conditioner_unit.sv =====
// Joystick conditioner top level: handshake, pipeline control, output holds.
// Depends on jc_pkg, jc_state and jc_map.
// A result passes the state stage, the two map stages and the output register.
// Throughput: one item per cycle; the four-stage pipeline stalls only on output stall.
// Reset (synchronous, active low): filters to centre, PWM on, style 0, holds 0,
// debounce 200000 us; the pipeline is emptied.
module joystick_conditioner_unit #(
    parameter int unsigned DEAD_ZONE     = jc_pkg::DEAD_ZONE_DEF,
    parameter int unsigned Y_OFFSET      = jc_pkg::Y_OFFSET_DEF,
    parameter int unsigned SCREEN_WIDTH  = jc_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = jc_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [23:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [11:0] i_sample_x,
    input  logic [11:0] i_sample_y,
    input  logic [47:0] i_time_us,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_red_level,
    output logic [7:0]  o_blue_level,
    output logic        o_green_on,
    output logic [1:0]  o_border_style,
    output logic [6:0]  o_square_x,
    output logic [5:0]  o_square_y,
    output logic        o_pwm_on
);

    logic r_va, r_vb, r_vc, r_vo;
    logic go_a, go_b, go_c, go_o;
    logic accept;

    jc_pkg::t_adv adv;
    jc_pkg::t_ctl ctl_a, ctl_c;
    logic [11:0]  fx_a, fy_a;
    logic [7:0]   red_c, blue_c;
    logic [6:0]   pos_x_c;
    logic [5:0]   pos_y_c;

    logic [7:0]   r_red, r_blue;
    logic [6:0]   r_pos_x;
    logic [5:0]   r_pos_y;
    logic [1:0]   r_style;
    logic         r_pwm;

    assign go_o   = !r_vo || !i_out_stall;
    assign go_c   = !r_vc || go_o;
    assign go_b   = !r_vb || go_c;
    assign go_a   = !r_va || go_b;
    assign accept = i_in_valid && go_a;
    assign adv    = '{b: go_b, c: go_c};

    jc_state #(
        .DEAD_ZONE (DEAD_ZONE)
    ) u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_kind        (i_kind),
        .i_sample_x    (i_sample_x),
        .i_sample_y    (i_sample_y),
        .i_time_us     (i_time_us),
        .o_ctl         (ctl_a),
        .o_fx          (fx_a),
        .o_fy          (fy_a)
    );

    jc_map #(
        .DEAD_ZONE     (DEAD_ZONE),
        .Y_OFFSET      (Y_OFFSET),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_map (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_ctl   (ctl_a),
        .i_fx    (fx_a),
        .i_fy    (fy_a),
        .o_ctl   (ctl_c),
        .o_red   (red_c),
        .o_blue  (blue_c),
        .o_pos_x (pos_x_c),
        .o_pos_y (pos_y_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_vc    <= 1'b0;
            r_vo    <= 1'b0;
            r_red   <= 8'd0;
            r_blue  <= 8'd0;
            r_pos_x <= 7'd0;
            r_pos_y <= 6'd0;
            r_style <= 2'd0;
            r_pwm   <= 1'b1;
        end else begin
            if (go_a) begin
                r_va <= accept;
            end
            if (go_b) begin
                r_vb <= r_va;
            end
            if (go_c) begin
                r_vc <= r_vb;
            end
            if (go_o) begin
                r_vo <= r_vc;
                if (r_vc) begin
                    r_style <= ctl_c.style;
                    r_pwm   <= ctl_c.pwm;
                    if (ctl_c.sample) begin
                        r_pos_x <= pos_x_c;
                        r_pos_y <= pos_y_c;
                        if (ctl_c.pwm) begin
                            r_red  <= red_c;
                            r_blue <= blue_c;
                        end
                    end
                    if (ctl_c.clr) begin
                        r_red  <= 8'd0;
                        r_blue <= 8'd0;
                    end
                end
            end
        end
    end

    assign o_in_stall     = !go_a;
    assign o_out_valid    = r_vo;
    assign o_red_level    = r_red;
    assign o_blue_level   = r_blue;
    assign o_green_on     = |r_style;
    assign o_border_style = r_style;
    assign o_square_x     = r_pos_x;
    assign o_square_y     = r_pos_y;
    assign o_pwm_on       = r_pwm;

    a_pwm_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pwm_on |-> (o_red_level == 8'd0 && o_blue_level == 8'd0))
        else $error("PWM levels nonzero while PWM is off");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_va && r_vb && r_vc && r_vo))
        else $error("input stalled with a bubble in the pipeline");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vc && !r_vo) |=> o_out_valid)
        else $error("last map stage did not reach the output register");

endmodule
